// ===== hw/rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the Base64 stream decoder
// Beat structs, the classified item passed from front to back, and the
// character-to-sextet lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  // Padding character '='
  localparam logic [7:0] PadCode = 8'h3D;

  // Alphabet offsets
  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;
  localparam logic [5:0] PlusSextet  = 6'd62;
  localparam logic [5:0] SlashSextet = 6'd63;

  // Position of a character within its group of four
  localparam logic [1:0] PosLead  = 2'd0;
  localparam logic [1:0] PosFirst = 2'd1;
  localparam logic [1:0] PosSecond = 2'd2;
  localparam logic [1:0] PosThird = 2'd3;

  // Queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Input beat
  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } b64d_in_t;

  // Output beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       stream_end;
  } b64d_out_t;

  // Classified character, front to back
  typedef struct packed {
    logic [5:0] sextet;
    logic       is_pad;
    logic       final_char;
  } b64d_item_t;

  // Map an ASCII code to its sextet; anything outside the alphabet gives 0
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      diff = c - 8'h41;
      return diff[5:0];
    end else if (c inside {[8'h61:8'h7A]}) begin
      diff = c - 8'h61;
      return diff[5:0] + LowerBase;
    end else if (c inside {[8'h30:8'h39]}) begin
      diff = c - 8'h30;
      return diff[5:0] + DigitBase;
    end else if (c == 8'h2B) begin
      return PlusSextet;
    end else if (c == 8'h2F) begin
      return SlashSextet;
    end
    return 6'd0;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front: character intake and classification
// Registers each accepted character as its sextet, padding flag and final flag.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front import b64d_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  b64d_in_t   in_data_i,
  output logic       item_valid_o,
  input  wire        item_stall_i,
  output b64d_item_t item_o
);

  logic       valid_q, valid_d;
  b64d_item_t item_q, item_d;
  logic       take;

  // Stall only while a held beat cannot move on
  assign in_stall_o = valid_q & item_stall_i;
  assign take       = in_valid_i & ~in_stall_o;

  // Classify the incoming character
  always_comb begin
    item_d.sextet     = sextet_of(in_data_i.char_code);
    item_d.is_pad     = (in_data_i.char_code == PadCode);
    item_d.final_char = in_data_i.final_char;
  end

  // Hold, refill or drain the stage
  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (!item_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue: short queue of classified characters
// Decouples intake from decoding so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue import b64d_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_valid_i,
  output logic       push_stall_o,
  input  b64d_item_t push_item_i,
  output logic       pop_valid_o,
  input  wire        pop_stall_i,
  output b64d_item_t pop_item_o
);

  b64d_item_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]       count_q, count_d;
  logic                     push, pop;

  assign push_stall_o = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & ~push_stall_o;
  assign pop          = pop_valid_o & ~pop_stall_i;

  // Track occupancy
  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign pop_item_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back: group tracking and byte assembly
// Joins consecutive sextets into bytes and registers one result per character.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back import b64d_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        item_valid_i,
  output logic       item_stall_o,
  input  b64d_item_t item_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output b64d_out_t  out_data_o
);

  logic [1:0] pos_q, pos_d;
  logic [5:0] held_q, held_d;
  logic       out_valid_q, out_valid_d;
  b64d_out_t  out_q, out_d;
  logic       take;

  // Take a new item whenever the output register is free or draining
  assign item_stall_o = out_valid_q & out_stall_i;
  assign take         = item_valid_i & ~item_stall_o;

  // Assemble the byte for this position
  always_comb begin
    out_d.data_byte  = 8'h00;
    out_d.byte_valid = 1'b0;
    out_d.stream_end = item_i.final_char;
    case (pos_q)
      PosFirst: begin
        out_d.data_byte  = {held_q, item_i.sextet[5:4]};
        out_d.byte_valid = 1'b1;
      end
      PosSecond: begin
        if (!item_i.is_pad) begin
          out_d.data_byte  = {held_q[3:0], item_i.sextet[5:2]};
          out_d.byte_valid = 1'b1;
        end
      end
      PosThird: begin
        if (!item_i.is_pad) begin
          out_d.data_byte  = {held_q[1:0], item_i.sextet};
          out_d.byte_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance the group, or restart it at the end of a stream
  always_comb begin
    if (item_i.final_char) begin
      pos_d  = PosLead;
      held_d = 6'd0;
    end else begin
      pos_d  = pos_q + 1'b1;
      held_d = item_i.sextet;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosLead;
      held_q      <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        pos_q  <= pos_d;
        held_q <= held_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming Base64 character decoder
// Accepts one character per beat and returns one result beat per character.
// ----------------------------------------------------------------------------
// Sustains one character per clock cycle in both directions while neither
// side stalls. Each beat gives exactly one result beat: a decoded byte with
// byte_valid set when the character completes one, and stream_end copied
// from final_char. A result passes from the intake register into the
// four-entry queue and then into the output register, where the group
// position and held sextet update.
// Either side may stall; the queue lets intake keep running while results
// wait to be taken.
`default_nettype none

module base64_stream_decoder import b64d_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  b64d_in_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_stall_i,
  output b64d_out_t out_data_o
);

  logic       fr_valid, fr_stall;
  b64d_item_t fr_item;
  logic       bk_valid, bk_stall;
  b64d_item_t bk_item;

  // Classify incoming characters
  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (fr_valid),
    .item_stall_i (fr_stall),
    .item_o       (fr_item)
  );

  // Buffer between intake and decoding
  b64d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_stall_o (fr_stall),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_stall_i  (bk_stall),
    .pop_item_o   (bk_item)
  );

  // Assemble bytes
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_stall_o (bk_stall),
    .item_i       (bk_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ===== test/base64_stream_checker.sv =====
// ----------------------------------------------------------------------------
// base64_stream_checker: scoreboard for the Base64 stream decoder
// Watches both channels, predicts one result beat per accepted character
// and compares every accepted result beat, field by field, in order.
// ----------------------------------------------------------------------------
module base64_stream_checker import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  b64d_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  b64d_out_t   out_data_i,
  output int unsigned pending_o,
  output int unsigned error_count_o
);

  // Decoder state as the checker sees it
  logic [1:0] group_pos;
  logic [5:0] held_sextet;

  // Decoded bytes still owed by the block, oldest first
  b64d_out_t owed_bytes[$];

  // Map a character to its 6-bit value; anything outside the alphabet is zero
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] val;
    val = 8'd0;
    if (c >= "A" && c <= "Z") begin
      val = c - "A";
    end else if (c >= "a" && c <= "z") begin
      val = c - "a" + 8'd26;
    end else if (c >= "0" && c <= "9") begin
      val = c - "0" + 8'd52;
    end else if (c == "+") begin
      val = 8'd62;
    end else if (c == "/") begin
      val = 8'd63;
    end
    return val[5:0];
  endfunction

  // Work out the result beat for one character and advance the group state
  function automatic b64d_out_t decode_beat(input b64d_in_t beat);
    b64d_out_t  res;
    logic [5:0] s;
    logic       pad;
    s   = char_value(beat.char_code);
    pad = (beat.char_code == PadCode);
    res = '0;
    res.stream_end = beat.final_char;
    case (group_pos)
      PosFirst: begin
        res.data_byte  = {held_sextet, s[5:4]};
        res.byte_valid = 1'b1;
      end
      PosSecond: begin
        if (!pad) begin
          res.data_byte  = {held_sextet[3:0], s[5:2]};
          res.byte_valid = 1'b1;
        end
      end
      PosThird: begin
        if (!pad) begin
          res.data_byte  = {held_sextet[1:0], s};
          res.byte_valid = 1'b1;
        end
      end
      default: ;
    endcase
    // Restart the group after the last character of a stream
    if (beat.final_char) begin
      group_pos   = PosLead;
      held_sextet = 6'd0;
    end else begin
      group_pos   = group_pos + 2'd1;
      held_sextet = s;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count_o = error_count_o + 1;
  endtask

  // Predict on every accepted character, compare on every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    b64d_out_t want;
    if (!rst_ni) begin
      group_pos     = PosLead;
      held_sextet   = 6'd0;
      owed_bytes.delete();
      pending_o     = 0;
      error_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        owed_bytes.push_back(decode_beat(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_bytes.size() == 0) begin
          report_mismatch("unexpected result beat", out_data_i, 0);
        end else begin
          want = owed_bytes.pop_front();
          if (out_data_i.byte_valid != want.byte_valid)
            report_mismatch("byte_valid", out_data_i.byte_valid, want.byte_valid);
          if (out_data_i.data_byte != want.data_byte)
            report_mismatch("data_byte", out_data_i.data_byte, want.data_byte);
          if (out_data_i.stream_end != want.stream_end)
            report_mismatch("stream_end", out_data_i.stream_end, want.stream_end);
        end
      end
      pending_o = owed_bytes.size();
    end
  end

endmodule

// ===== test/tb_base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder: testbench for the Base64 stream decoder
// Drives directed and random character streams under several idle and stall
// mixes, lets the checker score every result beat, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder import b64d_pkg::*; ();

  localparam int unsigned RandomBeats = 950;
  localparam int unsigned CycleLimit  = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  b64d_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  b64d_out_t   out_data;
  int unsigned pending;
  int unsigned error_count;

  int unsigned beats_sent;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  base64_stream_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  base64_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .pending_o     (pending),
    .error_count_o (error_count)
  );

  // Clock: 10 time units per period
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side at the rate of the current phase
  initial out_stall = 1'b0;
  always @(negedge clk_i) begin
    out_stall <= rst_ni && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Character for a 6-bit alphabet index
  function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
    if (idx < 6'd26) return "A" + idx;
    if (idx < 6'd52) return "a" + (idx - 6'd26);
    if (idx < 6'd62) return "0" + (idx - 6'd52);
    if (idx == 6'd62) return "+";
    return "/";
  endfunction

  // Present one character beat, idling first at the phase rate, and hold it
  // until accepted
  task automatic send_char(input logic [7:0] code, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = '{char_code: code, final_char: fin};
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    beats_sent = beats_sent + 1;
  endtask

  task automatic send_text(input string text, input logic fin_last);
    for (int i = 0; i < text.len(); i++)
      send_char(text[i], fin_last && (i == text.len() - 1));
  endtask

  // One random stream: mostly well-formed groups with padding or a short
  // tail, sometimes raw noise bytes with a random end marker
  task automatic send_random_stream();
    int n_chars;
    int n_pads;
    if ($urandom_range(0, 99) < 15) begin
      n_chars = $urandom_range(1, 6);
      for (int i = 0; i < n_chars; i++)
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end else begin
      n_chars = 4 * $urandom_range(1, 4);
      n_pads  = $urandom_range(0, 2);
      if ($urandom_range(0, 4) == 0) begin
        n_chars = n_chars - $urandom_range(1, 3);
        n_pads  = 0;
      end
      for (int i = 0; i < n_chars; i++)
        send_char((i >= n_chars - n_pads) ? PadCode
                                          : alphabet_char(6'($urandom_range(0, 63))),
                  i == n_chars - 1);
    end
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned idle_mix  [5];
    int unsigned stall_mix [5];
    int unsigned phase_end;
    idle_mix  = '{0, 54, 0, 21, 0};
    stall_mix = '{0, 0, 54, 21, 0};
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    beats_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: full group, one and two pad endings, alphabet edges,
    // padding at every position, bytes 0xFF and 0x00, lone final character
    send_text("TWFu", 1'b0);
    send_text("TWE=", 1'b1);
    send_text("TQ==", 1'b1);
    send_text("+/za", 1'b0);
    send_text("ZA90", 1'b0);
    send_text("===", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);

    // Random streams over the idle and stall mixes
    phase_end = beats_sent;
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct  = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      phase_end      = phase_end + RandomBeats / 5;
      while (beats_sent < phase_end) send_random_stream();
      // Hold off the sender until every result is back
      if (ph == 2) drain_results();
    end

    // Drain and let the pipeline settle
    drain_results();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
